### rtl/pctl_pkg.sv
package pctl_pkg;

  localparam int unsigned CodeLengthDefault  = 4;
  localparam int unsigned RecordDepthDefault = 4096;
  localparam int unsigned IndexEntries       = 677;
  localparam int unsigned IndexValueWidth    = 13;
  localparam int unsigned LimitCap           = 64;
  localparam int unsigned Letters            = 26;
  localparam logic [7:0]  LetterA            = 8'h61;

  localparam logic [1:0] CmdLoadIndex  = 2'd0;
  localparam logic [1:0] CmdLoadRecord = 2'd1;
  localparam logic [1:0] CmdQuery      = 2'd2;
  localparam logic [1:0] CmdIgnored    = 2'd3;

  typedef enum logic [1:0] {
    CmpBelow = 2'd0,
    CmpMatch = 2'd1,
    CmpAbove = 2'd2
  } cmp_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  index_slot;
    logic [12:0] index_value;
    logic [11:0] record_slot;
    logic [31:0] record_code;
    logic [31:0] record_pool_offset;
    logic [7:0]  record_word_length;
    logic [7:0]  record_rank;
    logic [31:0] query_code;
    logic [3:0]  query_length;
    logic [6:0]  query_limit;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] word_offset;
    logic [7:0]  word_length;
    logic [7:0]  candidate_rank;
    logic        exact_match;
    logic        last;
  } rsp_t;

endpackage

### rtl/prefix_code_table_lookup.sv
// channel   | valid       | stall        | payload
// request   | in_valid_i  | in_stall_o   | in_req_i   (pctl_pkg::req_t)
// result    | out_valid_o | out_stall_i  | out_rsp_o  (pctl_pkg::rsp_t)
// config    | cfg_we_i    | -            | cfg_wdata_i (record_count)
//
// load requests finish on acceptance; an invalid query goes straight to the closing state
// a query reads the two index cells, binary-searches the window, scans the matching
// records twice (exact matches first, then longer codes) and closes
// no clearing pass after reset: the user must write both memories before they are read; not enforced
// a full result register lets the scan run one candidate ahead of a stalled output
module prefix_code_table_lookup #(
  parameter int unsigned CODE_LENGTH  = pctl_pkg::CodeLengthDefault,
  parameter int unsigned RECORD_DEPTH = pctl_pkg::RecordDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [12:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pctl_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pctl_pkg::rsp_t  out_rsp_o
);
  import pctl_pkg::*;

  localparam int unsigned AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int unsigned PW = $clog2(RECORD_DEPTH + 1);

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StIx1  = 8'b0000_0010,
    StIx2  = 8'b0000_0100,
    StSrch = 8'b0000_1000,
    StScmp = 8'b0001_0000,
    StScan = 8'b0010_0000,
    StSchk = 8'b0100_0000,
    StDone = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [31:0] code;
    logic [31:0] offset;
    logic [7:0]  len;
    logic [7:0]  rank;
  } rec_t;

  function automatic cmp_e cmp_code(logic [31:0] rec, logic [31:0] q, logic [3:0] qlen);
    cmp_e       r;
    logic       done;
    logic [7:0] rc;
    logic [7:0] qc;
    r    = CmpMatch;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      rc = 8'(rec >> (8 * i));
      qc = 8'(q >> (8 * i));
      if (!done && (i < CODE_LENGTH) && (i < 32'(qlen))) begin
        if (rc == 8'd0) begin
          r    = CmpBelow;
          done = 1'b1;
        end else if (rc != qc) begin
          r    = (rc < qc) ? CmpBelow : CmpAbove;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  logic [12:0] idx_mem [IndexEntries];
  rec_t        rec_mem [RECORD_DEPTH];
  logic [12:0] idx_rd_q;
  rec_t        rec_rd_q;

  state_e      state_q, state_d;
  logic [12:0] count_q;
  logic [31:0] q_q, q_d;
  logic [3:0]  qlen_q, qlen_d;
  logic [6:0]  limit_q, limit_d;
  logic        use_cnt_q, use_cnt_d;
  logic [12:0] wlo_q, wlo_d;
  logic [PW-1:0] lo_q, lo_d, hi_q, hi_d, whi_q, whi_d, start_q, start_d;
  logic [PW-1:0] i_q, i_d, mid_q, mid_d;
  logic        pass_q, pass_d;
  logic [6:0]  n_q, n_d;
  logic        pend_vld_q, pend_vld_d;
  rsp_t        pend_q, pend_d;
  logic        out_vld_q, out_vld_d;
  rsp_t        out_q, out_d;

  logic          in_acc, out_free;
  logic          idx_re, rec_re;
  logic [9:0]    idx_ra;
  logic [AW-1:0] rec_ra;
  logic [PW-1:0] cnt, mid, wlo_c, whi_c;
  logic [31:0]   whi_raw, slot_w;
  logic [7:0]    c0, c1;
  logic [4:0]    c0i, c1i;
  logic [9:0]    k0, k1;
  logic          qbad;
  cmp_e          cmp_mid, cmp_scan;
  logic          exact;
  rsp_t          cand, none_rsp;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  assign cnt = (32'(count_q) > RECORD_DEPTH) ? PW'(RECORD_DEPTH) : PW'(count_q);
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign slot_w = 32'(in_req_i.record_slot);

  // query decode
  assign c0  = in_req_i.query_code[7:0];
  assign c1  = (in_req_i.query_length >= 4'd2) ? in_req_i.query_code[15:8] : LetterA;
  assign c0i = 5'(c0 - LetterA);
  assign c1i = 5'(c1 - LetterA);
  assign k0  = 10'(32'(c0i) * Letters);
  assign qbad = (in_req_i.query_length == 4'd0) || (32'(in_req_i.query_length) > CODE_LENGTH)
             || (in_req_i.query_limit == 7'd0)
             || (c0 < LetterA) || (c0 > LetterA + 8'd25)
             || (c1 < LetterA) || (c1 > LetterA + 8'd25);
  assign k1 = (in_req_i.query_length == 4'd1) ? k0 : 10'(k0 + 10'(c1i));

  // clamp window
  assign wlo_c   = (32'(wlo_q) > 32'(cnt)) ? cnt : PW'(wlo_q);
  assign whi_raw = use_cnt_q ? 32'(cnt) : 32'(idx_rd_q);
  assign whi_c   = (whi_raw > 32'(cnt)) ? cnt : PW'(whi_raw);

  assign cmp_mid  = cmp_code(rec_rd_q.code, q_q, qlen_q);
  assign cmp_scan = cmp_mid;
  assign exact = (32'(qlen_q) == CODE_LENGTH) || (8'(rec_rd_q.code >> {qlen_q, 3'b000}) == 8'd0);

  always_comb begin
    cand.found          = 1'b1;
    cand.word_offset    = rec_rd_q.offset;
    cand.word_length    = rec_rd_q.len;
    cand.candidate_rank = rec_rd_q.rank;
    cand.exact_match    = exact;
    cand.last           = 1'b0;
    none_rsp            = '0;
    none_rsp.last       = 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    q_d        = q_q;
    qlen_d     = qlen_q;
    limit_d    = limit_q;
    use_cnt_d  = use_cnt_q;
    wlo_d      = wlo_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    whi_d      = whi_q;
    start_d    = start_q;
    i_d        = i_q;
    mid_d      = mid_q;
    pass_d     = pass_q;
    n_d        = n_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    idx_re     = 1'b0;
    idx_ra     = k1;
    rec_re     = 1'b0;
    rec_ra     = i_q[AW-1:0];
    unique case (state_q)
      StIdle: begin
        if (in_acc && (in_req_i.command == CmdQuery)) begin
          q_d        = in_req_i.query_code;
          qlen_d     = in_req_i.query_length;
          limit_d    = (32'(in_req_i.query_limit) > LimitCap) ? 7'(LimitCap)
                                                              : in_req_i.query_limit;
          n_d        = '0;
          pend_vld_d = 1'b0;
          if (in_req_i.query_length == 4'd1) begin
            use_cnt_d = (c0i == 5'd25);
          end else begin
            use_cnt_d = (32'(k1) + 32'd1 >= IndexEntries);
          end
          if (qbad) begin
            state_d = StDone;
          end else begin
            idx_re  = 1'b1;
            idx_ra  = k1;
            state_d = StIx1;
          end
        end
      end
      StIx1: begin
        wlo_d  = idx_rd_q;
        idx_re = !use_cnt_q;
        if (qlen_q == 4'd1) begin
          idx_ra = 10'(32'(q_q[7:0] - LetterA + 8'd1) * Letters);
        end else begin
          idx_ra = 10'(32'(5'(q_q[7:0] - LetterA)) * Letters
                        + 32'(5'(q_q[15:8] - LetterA)) + 32'd1);
        end
        state_d = StIx2;
      end
      StIx2: begin
        lo_d    = wlo_c;
        hi_d    = whi_c;
        whi_d   = whi_c;
        state_d = StSrch;
      end
      StSrch: begin
        if (lo_q < hi_q) begin
          rec_re  = 1'b1;
          rec_ra  = mid[AW-1:0];
          mid_d   = mid;
          state_d = StScmp;
        end else begin
          start_d = lo_q;
          i_d     = lo_q;
          pass_d  = 1'b0;
          state_d = StScan;
        end
      end
      StScmp: begin
        if (cmp_mid == CmpBelow) begin
          lo_d = mid_q + PW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = StSrch;
      end
      StScan: begin
        if ((i_q < whi_q) && (n_q < limit_q)) begin
          rec_re  = 1'b1;
          rec_ra  = i_q[AW-1:0];
          state_d = StSchk;
        end else if (!pass_q) begin
          pass_d  = 1'b1;
          i_d     = start_q;
        end else begin
          state_d = StDone;
        end
      end
      StSchk: begin
        if (cmp_scan != CmpMatch) begin
          if (!pass_q) begin
            pass_d  = 1'b1;
            i_d     = start_q;
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end else if (exact != pass_q) begin
          if (!pend_vld_q || out_free) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = pend_q;
            end
            pend_vld_d = 1'b1;
            pend_d     = cand;
            n_d        = n_q + 7'd1;
            i_d        = i_q + PW'(1);
            state_d    = StScan;
          end
        end else begin
          i_d     = i_q + PW'(1);
          state_d = StScan;
        end
      end
      StDone: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          if (pend_vld_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d = none_rsp;
          end
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_req_i.command == CmdLoadIndex)
        && (32'(in_req_i.index_slot) < IndexEntries)) begin
      idx_mem[in_req_i.index_slot] <= in_req_i.index_value;
    end
    if (idx_re) begin
      idx_rd_q <= idx_mem[idx_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_req_i.command == CmdLoadRecord) && (slot_w < RECORD_DEPTH)) begin
      rec_mem[slot_w[AW-1:0]] <= '{code:   in_req_i.record_code,
                                   offset: in_req_i.record_pool_offset,
                                   len:    in_req_i.record_word_length,
                                   rank:   in_req_i.record_rank};
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    qlen_q    <= qlen_d;
    limit_q   <= limit_d;
    use_cnt_q <= use_cnt_d;
    wlo_q     <= wlo_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    whi_q     <= whi_d;
    start_q   <= start_d;
    i_q       <= i_d;
    mid_q     <= mid_d;
    pass_q    <= pass_d;
    n_q       <= n_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

endmodule

### rtl/pctl_checker.sv
module pctl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input pctl_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input pctl_pkg::rsp_t out_rsp_o
);
  import pctl_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed under stall");

  // a query request keeps the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.command == CmdQuery) |=> in_stall_o)
    else $error("query request did not occupy the block");

  // load and ignored requests finish at once
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.command != CmdQuery) |=> !in_stall_o)
    else $error("load request held the block");

  // a query is still open while a non-final result leaves
  a_open_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_rsp_o.last |-> in_stall_o)
    else $error("block idle with query results outstanding");

endmodule

bind prefix_code_table_lookup pctl_checker u_pctl_checker (.*);

### tb/sv/prefix_code_table_lookup_tb.sv
`timescale 1ns / 100ps
module prefix_code_table_lookup_tb;
  import pctl_pkg::*;

  localparam int unsigned Depth = RecordDepthDefault;
  localparam int unsigned Records = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  int idle_pct = 0;
  int stall_pct = 0;

  prefix_code_table_lookup dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

  class lookup_scoreboard;
    logic [12:0] prefix_index[IndexEntries];
    logic [31:0] codes[Depth];
    logic [31:0] offsets[Depth];
    logic [7:0]  lengths[Depth];
    logic [7:0]  ranks[Depth];
    int unsigned count;
    rsp_t pending[$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void set_count(logic [12:0] v);
      count = (v > Depth) ? Depth : v;
    endfunction

    function cmp_e compare(logic [31:0] rec, logic [31:0] q, int unsigned qlen);
      logic [7:0] rc, qc;
      for (int i = 0; i < CodeLengthDefault && i < qlen; i++) begin
        rc = rec[8*i +: 8];
        qc = q[8*i +: 8];
        if (rc == 8'd0) return CmpBelow;
        if (rc != qc) return (rc < qc) ? CmpBelow : CmpAbove;
      end
      return CmpMatch;
    endfunction

    function void push_none();
      rsp_t r;
      r = '0;
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void predict_query(req_t r);
      int unsigned qlen, limit, c0, c1, wlo, whi, lo, hi, mid, n, k;
      logic exact;
      rsp_t o;
      qlen = r.query_length;
      limit = (r.query_limit > LimitCap) ? LimitCap : r.query_limit;
      if (qlen == 0 || qlen > CodeLengthDefault || limit == 0) begin
        push_none();
        return;
      end
      c0 = r.query_code[7:0];
      c1 = (qlen >= 2) ? r.query_code[15:8] : LetterA;
      if (c0 < LetterA || c0 > LetterA + 25 || c1 < LetterA || c1 > LetterA + 25) begin
        push_none();
        return;
      end
      c0 -= LetterA;
      c1 -= LetterA;
      if (qlen == 1) begin
        wlo = prefix_index[c0 * Letters];
        whi = (c0 + 1 <= 25) ? prefix_index[(c0 + 1) * Letters] : count;
      end else begin
        k = c0 * Letters + c1;
        wlo = prefix_index[k];
        whi = (k + 1 < IndexEntries) ? prefix_index[k + 1] : count;
      end
      if (wlo > count) wlo = count;
      if (whi > count) whi = count;
      lo = wlo;
      hi = whi;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (compare(codes[mid], r.query_code, qlen) == CmpBelow) lo = mid + 1;
        else hi = mid;
      end
      n = 0;
      for (int pass = 0; pass < 2; pass++) begin
        for (int unsigned i = lo; i < whi && n < limit; i++) begin
          if (compare(codes[i], r.query_code, qlen) != CmpMatch) break;
          exact = (qlen == CodeLengthDefault || codes[i][8*qlen +: 8] == 8'd0);
          if (exact != (pass == 0)) continue;
          o.found = 1'b1;
          o.word_offset = offsets[i];
          o.word_length = lengths[i];
          o.candidate_rank = ranks[i];
          o.exact_match = exact;
          o.last = 1'b0;
          pending.push_back(o);
          n++;
        end
      end
      if (n == 0) push_none();
      else pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void note_request(req_t r);
      case (r.command)
        CmdLoadIndex: begin
          if (r.index_slot < IndexEntries) prefix_index[r.index_slot] = r.index_value;
        end
        CmdLoadRecord: begin
          codes[r.record_slot] = r.record_code;
          offsets[r.record_slot] = r.record_pool_offset;
          lengths[r.record_slot] = r.record_word_length;
          ranks[r.record_slot] = r.record_rank;
        end
        CmdQuery: predict_query(r);
        default: ;
      endcase
    endfunction

    function void check(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, a.found); errors++;
      end
      if (a.word_offset !== e.word_offset) begin
        $error("word_offset: expected %0h actual %0h", e.word_offset, a.word_offset); errors++;
      end
      if (a.word_length !== e.word_length) begin
        $error("word_length: expected %0d actual %0d", e.word_length, a.word_length); errors++;
      end
      if (a.candidate_rank !== e.candidate_rank) begin
        $error("candidate_rank: expected %0d actual %0d", e.candidate_rank, a.candidate_rank);
        errors++;
      end
      if (a.exact_match !== e.exact_match) begin
        $error("exact_match: expected %0d actual %0d", e.exact_match, a.exact_match); errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0d actual %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  lookup_scoreboard sb = new();

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_rsp_o);
  end

  initial begin
    #20ms;
    $display("FAIL prefix_code_table_lookup");
    $finish;
  end

  task automatic send(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic write_count(logic [12:0] v);
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic req_t noise();
    req_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return r;
  endfunction

  function automatic req_t query(logic [31:0] code, int unsigned len, int unsigned lim);
    req_t r;
    r = noise();
    r.command = CmdQuery;
    r.query_code = code;
    r.query_length = 4'(len);
    r.query_limit = 7'(lim);
    return r;
  endfunction

  function automatic req_t record_write(int unsigned slot, logic [31:0] code, logic [7:0] rank);
    req_t r;
    r = noise();
    r.command = CmdLoadRecord;
    r.record_slot = 12'(slot);
    r.record_code = code;
    r.record_rank = rank;
    return r;
  endfunction

  function automatic req_t index_write(int unsigned slot, int unsigned v);
    req_t r;
    r = noise();
    r.command = CmdLoadIndex;
    r.index_slot = 10'(slot);
    r.index_value = 13'(v);
    return r;
  endfunction

  // most query prefixes come from loaded record codes
  function automatic req_t random_request();
    int unsigned pick, len, lim, keep;
    logic [31:0] code;
    logic [63:0] mask;
    pick = $urandom_range(99);
    lim = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 20);
    if (pick < 5) return index_write($urandom_range(1023), $urandom_range(Records));
    if (pick < 8) begin
      code = $urandom;
      code[7:0] = LetterA + 8'($urandom_range(1));
      code[15:8] = LetterA + 8'($urandom_range(2));
      return record_write($urandom_range(Depth - 1), code, 8'($urandom));
    end
    if (pick < 10) begin
      random_request = noise();
      random_request.command = CmdIgnored;
      return random_request;
    end
    if (pick < 85) begin
      code = sb.codes[$urandom_range(Records - 1)];
      len = $urandom_range(1, CodeLengthDefault);
      keep = (len < 2) ? 2 : len;
      mask = (64'd1 << (8 * keep)) - 64'd1;
      if ($urandom_range(1)) code = 32'((64'(code) & mask) | (64'($urandom) & ~mask));
      if (len >= 3 && $urandom_range(3) == 0)
        code[8*(len-1) +: 8] = LetterA + 8'($urandom_range(25));
      return query(code, len, lim);
    end
    code = $urandom;
    code[7:0] = 8'h7b + 8'($urandom_range(132));
    return query(code, $urandom_range(15), lim);
  endfunction

  longint unsigned keys[Records];
  int unsigned ix_set[14] = '{0, 1, 2, 3, 24, 25, 26, 27, 28, 29, 52, 650, 675, 676};
  int idle_set[4] = '{0, 57, 0, 6};
  int stall_set[4] = '{0, 0, 57, 6};
  logic [12:0] count_set[4] = '{13'd8191, 13'd4096, 13'd12, 13'd1};

  initial begin
    logic [7:0] b[4];
    int unsigned len, p, sk;
    logic [31:0] code;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(record_write(Depth - 1, 32'hffff_ffff, 8'hff));
    send(record_write(0, 32'h0, 8'h0));
    for (int i = 0; i < Records; i++) begin
      len = $urandom_range(1, CodeLengthDefault);
      b[0] = LetterA + 8'($urandom_range(1));
      for (int j = 1; j < 4; j++) b[j] = (j < len) ? LetterA + 8'($urandom_range(2)) : 8'd0;
      keys[i] = {b[0], b[1], b[2], b[3], 8'($urandom), 24'd0};
    end
    keys.sort();
    for (int i = 0; i < Records; i++)
      send(record_write(i, {keys[i][39:32], keys[i][47:40], keys[i][55:48], keys[i][63:56]},
                        keys[i][31:24]));
    send(index_write(1023, 4096));
    send(index_write(700, 4095));
    foreach (ix_set[e]) begin
      p = 0;
      while (p < Records) begin
        sk = (keys[p][63:56] - LetterA) * Letters
             + (keys[p][55:48] == 8'd0 ? 0 : keys[p][55:48] - LetterA);
        if (sk >= ix_set[e]) break;
        p++;
      end
      send(index_write(ix_set[e], p));
    end

    // directed
    drain();
    write_count(13'd0);
    send(query(32'h0000_6261, 2, 5));
    drain();
    write_count(13'(Records));
    code = sb.codes[5];
    send(query(code, 1, 127));
    send(query(code, 2, 1));
    send(query(code, CodeLengthDefault, 64));
    send(query(code, 3, 3));
    send(query(code, 0, 5));
    send(query(code, 5, 5));
    send(query(code, 15, 5));
    send(query(code, 2, 0));
    send(query(32'h0000_6241, 2, 5));
    send(query(32'h0000_607b, 2, 5));
    send(query(32'h0000_6160, 2, 5));
    send(query(32'h0000_007a, 1, 10));
    send(query(32'h0000_7a7a, 2, 10));
    send(query(32'h7a7a_7a7a, 4, 10));
    send(query(32'h0000_6179, 2, 4));
    send(query(32'hffff_ffff, 4, 4));
    send(query(sb.codes[Depth - 1], 2, 64));
    begin
      req_t r;
      r = noise();
      r.command = CmdIgnored;
      send(r);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_count(count_set[ph]);
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < 18; n++) begin
        if (n == 6) drain();
        send(random_request());
      end
    end

    in_valid_i <= 1'b0;
    for (int t = 0; t < 200000 && sb.pending.size() != 0; t++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS prefix_code_table_lookup");
    end else begin
      $display("FAIL prefix_code_table_lookup");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pctl_pkg.sv
rtl/prefix_code_table_lookup.sv
rtl/pctl_checker.sv
tb/sv/prefix_code_table_lookup_tb.sv
